// ===== rtl/spbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbd_pkg
// Shared types and constants for the seeded permutation byte decoder.
// ----------------------------------------------------------------------------
package spbd_pkg;

  // Field widths
  localparam int SEED_W      = 32;
  localparam int SEED_MAG_W  = 31;
  localparam int BYTE_W      = 8;

  // Key derivation constants
  localparam int DIV_BASE        = 250;
  localparam int MOD_BASE        = 254;
  localparam int STRIDE_BASE     = 6;
  localparam int SWAP_ROUNDS_DEF = 10000;

  // Reciprocal divide: seed / 250 = ((seed >> 1) * DIV_RECIP) >> DIV_SHIFT,
  // exact for every 31-bit seed; quotient / 254 uses MOD_RECIP the same way
  localparam int          QUO_W       = 24;
  localparam int          DIV_RECIP_W = 31;
  localparam int          DIV_SHIFT   = 37;
  localparam logic [30:0] DIV_RECIP   = 31'd1099511628;
  localparam int          MOD_RECIP_W = 24;
  localparam int          MOD_SHIFT   = 30;
  localparam logic [23:0] MOD_RECIP   = 24'd8454661;

  // Table geometry: the permutation is split into an even and an odd bank
  localparam int TABLE_DEPTH = 256;
  localparam int BANK_DEPTH  = 128;

  // Front queue depth
  localparam int QUEUE_DEPTH = 4;

  // Command codes on the input stream
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Item class decided by the front part
  typedef enum logic [1:0] {
    KIND_DECODE   = 2'd0,
    KIND_LOAD     = 2'd1,
    KIND_LOAD_ERR = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic [SEED_MAG_W-1:0]   seed;
    logic [BYTE_W-1:0]       cipher_byte;
    logic [BYTE_W-1:0]       position_low;
  } queue_item_t;

  // Key derivation request from the back part
  typedef struct packed {
    logic                    start;
    logic [SEED_MAG_W-1:0]   seed;
  } key_req_t;

  // Write port into the inverse table
  typedef struct packed {
    logic                    we;
    logic [BYTE_W-1:0]       addr;
    logic [BYTE_W-1:0]       data;
  } inv_wr_t;

endpackage

// ===== rtl/spbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbd_front
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module spbd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [spbd_pkg::SEED_W-1:0]         in_seed,
  input  logic [spbd_pkg::BYTE_W-1:0]         in_cipher,
  input  logic [spbd_pkg::BYTE_W-1:0]         in_pos,
  output logic                                q_valid,
  output spbd_pkg::queue_item_t               q_item,
  input  logic                                q_pop
);

  localparam int PTR_W = $clog2(spbd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(spbd_pkg::QUEUE_DEPTH + 1);

  spbd_pkg::queue_item_t slots [spbd_pkg::QUEUE_DEPTH];
  spbd_pkg::queue_item_t item_in;
  logic [PTR_W-1:0]      wptr;
  logic [PTR_W-1:0]      rptr;
  logic [CNT_W-1:0]      count;
  logic                  push;

  assign in_ready = (count != CNT_W'(spbd_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rptr];

  // Classify: a load with the sign bit set is an error item
  always_comb begin
    item_in.seed         = in_seed[spbd_pkg::SEED_MAG_W-1:0];
    item_in.cipher_byte  = in_cipher;
    item_in.position_low = in_pos;
    if (in_cmd == spbd_pkg::CMD_DECODE) begin
      item_in.kind = spbd_pkg::KIND_DECODE;
    end else if (in_seed[spbd_pkg::SEED_W-1]) begin
      item_in.kind = spbd_pkg::KIND_LOAD_ERR;
    end else begin
      item_in.kind = spbd_pkg::KIND_LOAD;
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(spbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == PTR_W'(spbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (q_pop |-> q_valid) and (count <= CNT_W'(spbd_pkg::QUEUE_DEPTH)))
    else $error("front queue over or underflow");
`endif

endmodule

// ===== rtl/spbd_keygen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbd_keygen
// Derives the key tables: reciprocal divide of the seed by 250, identity fill,
// adjacent swap rounds over an even/odd banked permutation, inverse sweep.
// ----------------------------------------------------------------------------
module spbd_keygen #(
  parameter int SWAP_ROUNDS = spbd_pkg::SWAP_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spbd_pkg::key_req_t    req,
  output logic                  done,
  output spbd_pkg::inv_wr_t     inv_wr
);

  localparam int RND_W   = $clog2(SWAP_ROUNDS + 1);
  localparam int BANK_AW = $clog2(spbd_pkg::BANK_DEPTH);
  localparam int CNT_W   = $clog2(spbd_pkg::TABLE_DEPTH + 1);
  localparam int BW      = spbd_pkg::BYTE_W;
  localparam int QW      = spbd_pkg::QUO_W;
  localparam int PD_W    = spbd_pkg::SEED_MAG_W - 1 + spbd_pkg::DIV_RECIP_W;
  localparam int PM_W    = spbd_pkg::QUO_W - 1 + spbd_pkg::MOD_RECIP_W;
  localparam int DIV_LAST = 3;

  typedef enum logic [6:0] {
    K_IDLE = 7'b0000001,
    K_DIV  = 7'b0000010,
    K_PREP = 7'b0000100,
    K_INIT = 7'b0001000,
    K_RD   = 7'b0010000,
    K_WR   = 7'b0100000,
    K_INV  = 7'b1000000
  } kstate_t;

  kstate_t                         state;
  logic [CNT_W-1:0]                cnt;
  logic [RND_W-1:0]                rnd;
  logic [spbd_pkg::SEED_MAG_W-1:0] sreg;
  logic [PD_W-1:0]                 prod_div;
  logic [QW-1:0]                   quo;
  logic [PM_W-1:0]                 prod_mod;
  logic [BW-1:0]                   rem;
  logic [BW-1:0]                   om;
  logic [BW-1:0]                   stride_m;
  logic [BW-1:0]                   r;
  logic [BW-1:0]                   ev_rd;
  logic [BW-1:0]                   od_rd;
  logic                            inv_v;
  logic [BW-1:0]                   inv_idx;

  logic [BW-1:0] even_bank [spbd_pkg::BANK_DEPTH];
  logic [BW-1:0] odd_bank  [spbd_pkg::BANK_DEPTH];

  logic [QW-1:0]      quo_c;
  logic [BW-1:0]      rem_next;
  logic [BW-2:0]      q2_lo;
  logic [BW-1:0]      om_next;
  logic [BW:0]        stride_t;
  logic [BW-1:0]      stride_mod;
  logic [BW:0]        r_first_t;
  logic [BW-1:0]      r_first;
  logic [BW:0]        r_step_t;
  logic [BW-1:0]      r_next;
  logic [BW-1:0]      k_lo;
  logic [BW-1:0]      k_hi;
  logic [BANK_AW-1:0] ea;
  logic [BANK_AW-1:0] oa;
  logic [BANK_AW-1:0] rd_ea;
  logic [BANK_AW-1:0] rd_oa;

  // Quotient from the product; remainder mod 250 and offset mod 254 need only
  // the low byte, since 250 is -6 and 254 is -2 modulo 256
  always_comb begin
    quo_c    = prod_div[spbd_pkg::DIV_SHIFT +: QW];
    rem_next = sreg[BW-1:0] + {quo_c[BW-3:0], 2'b00} + {quo_c[BW-2:0], 1'b0};
    q2_lo    = prod_mod[spbd_pkg::MOD_SHIFT +: (BW-1)];
    om_next  = quo[BW-1:0] + {q2_lo, 1'b0};
  end

  // Stride reduced mod 254 and the first swap index
  always_comb begin
    stride_t   = (BW+1)'(rem) + (BW+1)'(spbd_pkg::STRIDE_BASE);
    stride_mod = (stride_t >= (BW+1)'(spbd_pkg::MOD_BASE)) ?
                 BW'(stride_t - (BW+1)'(spbd_pkg::MOD_BASE)) : stride_t[BW-1:0];
    r_first_t  = (BW+1)'(stride_mod) + (BW+1)'(om);
    r_first    = (r_first_t >= (BW+1)'(spbd_pkg::MOD_BASE)) ?
                 BW'(r_first_t - (BW+1)'(spbd_pkg::MOD_BASE)) : r_first_t[BW-1:0];
  end

  // Next swap index and bank addresses of entries k and k+1
  always_comb begin
    r_step_t = (BW+1)'(r) + (BW+1)'(stride_m);
    r_next   = (r_step_t >= (BW+1)'(spbd_pkg::MOD_BASE)) ?
               BW'(r_step_t - (BW+1)'(spbd_pkg::MOD_BASE)) : r_step_t[BW-1:0];
    k_lo     = r + BW'(1);
    k_hi     = r + BW'(2);
    ea       = k_hi[BW-1:1];
    oa       = k_lo[BW-1:1];
    rd_ea    = (state == K_INV) ? cnt[BW-1:1] : ea;
    rd_oa    = (state == K_INV) ? cnt[BW-1:1] : oa;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= K_IDLE;
      cnt   <= '0;
      rnd   <= '0;
    end else begin
      unique case (state)
        K_IDLE: begin
          if (req.start) begin
            cnt   <= '0;
            state <= K_DIV;
          end
        end
        K_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_LAST)) begin
            state <= K_PREP;
          end
        end
        K_PREP: begin
          cnt   <= '0;
          rnd   <= '0;
          state <= K_INIT;
        end
        K_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt[BANK_AW-1:0] == BANK_AW'(spbd_pkg::BANK_DEPTH - 1)) begin
            state <= K_RD;
          end
        end
        K_RD: begin
          state <= K_WR;
        end
        K_WR: begin
          rnd <= rnd + 1'b1;
          if (rnd == RND_W'(SWAP_ROUNDS - 1)) begin
            cnt   <= '0;
            state <= K_INV;
          end else begin
            state <= K_RD;
          end
        end
        K_INV: begin
          if (cnt == CNT_W'(spbd_pkg::TABLE_DEPTH)) begin
            state <= K_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= K_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, including the divide pipeline stepped through K_DIV
  always_ff @(posedge clk) begin
    if (state == K_IDLE && req.start) begin
      sreg <= req.seed;
    end
    if (state == K_DIV) begin
      prod_div <= PD_W'(sreg[spbd_pkg::SEED_MAG_W-1:1]) * PD_W'(spbd_pkg::DIV_RECIP);
      quo      <= quo_c;
      rem      <= rem_next;
      prod_mod <= PM_W'(quo[QW-1:1]) * PM_W'(spbd_pkg::MOD_RECIP);
      om       <= om_next;
    end
    if (state == K_PREP) begin
      stride_m <= stride_mod;
      r        <= r_first;
    end else if (state == K_WR) begin
      r <= r_next;
    end
  end

  // Permutation banks: fill identity, swap, read back for the inverse
  always_ff @(posedge clk) begin
    if (state == K_INIT) begin
      even_bank[cnt[BANK_AW-1:0]] <= {cnt[BANK_AW-1:0], 1'b0};
      odd_bank[cnt[BANK_AW-1:0]]  <= {cnt[BANK_AW-1:0], 1'b1};
    end else if (state == K_WR) begin
      even_bank[ea] <= od_rd;
      odd_bank[oa]  <= ev_rd;
    end
    if (state == K_RD || state == K_INV) begin
      ev_rd <= even_bank[rd_ea];
      od_rd <= odd_bank[rd_oa];
    end
  end

  // Inverse write pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_v <= 1'b0;
    end else begin
      inv_v <= (state == K_INV) && (cnt != CNT_W'(spbd_pkg::TABLE_DEPTH));
    end
    inv_idx <= cnt[BW-1:0];
  end

  assign inv_wr.we   = inv_v;
  assign inv_wr.addr = inv_idx[0] ? od_rd : ev_rd;
  assign inv_wr.data = inv_idx;
  assign done        = (state == K_INV) && (cnt == CNT_W'(spbd_pkg::TABLE_DEPTH));

`ifndef SYNTHESIS
  a_inv_in_sweep: assert property (@(posedge clk) disable iff (rst)
    inv_wr.we |-> (state == K_INV))
    else $error("inverse write outside sweep");
  a_swap_index: assert property (@(posedge clk) disable iff (rst)
    (state == K_RD) |=> (state == K_WR) && (r < BW'(spbd_pkg::MOD_BASE)))
    else $error("swap index out of range");
`endif

endmodule

// ===== rtl/spbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbd_back
// Executes queued items: decodes through the inverse table, starts key
// derivation and holds the result register.
// ----------------------------------------------------------------------------
module spbd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  spbd_pkg::queue_item_t         q_item,
  output logic                          q_pop,
  output spbd_pkg::key_req_t            key_req,
  input  logic                          key_done,
  input  spbd_pkg::inv_wr_t             inv_wr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spbd_pkg::BYTE_W-1:0]   out_plain,
  output logic                          out_error
);

  localparam int BW = spbd_pkg::BYTE_W;

  typedef enum logic [1:0] {
    B_RUN = 2'b01,
    B_KEY = 2'b10
  } bstate_t;

  bstate_t              state;
  logic                 key_loaded;
  logic [BW-1:0]        inv_mem [spbd_pkg::TABLE_DEPTH];
  logic [BW-1:0]        rdata;
  logic                 s1_v;
  spbd_pkg::item_kind_t s1_kind;
  logic [BW-1:0]        s1_cipher;
  logic [BW-1:0]        s1_pos;
  logic                 s1_move;
  logic                 s1_free;
  logic                 is_key;
  logic                 pop_short;
  logic                 pop_key;
  logic [BW-1:0]        res_plain;
  logic                 res_error;

  // Issue control
  assign s1_move   = s1_v && (!out_valid || out_ready);
  assign s1_free   = !s1_v || s1_move;
  assign is_key    = (q_item.kind == spbd_pkg::KIND_LOAD);
  assign pop_short = (state == B_RUN) && q_valid && !is_key && s1_free;
  assign pop_key   = (state == B_RUN) && q_valid && is_key && !s1_v;
  assign q_pop     = pop_short || pop_key;

  assign key_req.start = pop_key;
  assign key_req.seed  = q_item.seed;

  // Key load sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_RUN;
      key_loaded <= 1'b0;
    end else begin
      unique case (state)
        B_RUN: begin
          if (pop_key) begin
            state <= B_KEY;
          end
        end
        B_KEY: begin
          if (key_done) begin
            state      <= B_RUN;
            key_loaded <= 1'b1;
          end
        end
        default: begin
          state <= B_RUN;
        end
      endcase
    end
  end

  // Inverse table: written by the key sweep, read at decode issue
  always_ff @(posedge clk) begin
    if (inv_wr.we) begin
      inv_mem[inv_wr.addr] <= inv_wr.data;
    end
    if (pop_short) begin
      rdata <= inv_mem[q_item.cipher_byte];
    end
  end

  // Stage one: item waiting for its table data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (pop_short || key_done) begin
      s1_v <= 1'b1;
    end else if (s1_move) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_short) begin
      s1_kind   <= q_item.kind;
      s1_cipher <= q_item.cipher_byte;
      s1_pos    <= q_item.position_low;
    end else if (key_done) begin
      s1_kind <= spbd_pkg::KIND_LOAD;
    end
  end

  // Form the result
  always_comb begin
    res_plain = '0;
    res_error = 1'b0;
    unique case (s1_kind)
      spbd_pkg::KIND_DECODE: begin
        res_plain = key_loaded ? (rdata - s1_pos) : s1_cipher;
      end
      spbd_pkg::KIND_LOAD_ERR: begin
        res_error = 1'b1;
      end
      spbd_pkg::KIND_LOAD: begin
        res_plain = '0;
      end
      default: begin
        res_plain = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_plain <= res_plain;
      out_error <= res_error;
    end
  end

`ifndef SYNTHESIS
  a_key_alone: assert property (@(posedge clk) disable iff (rst)
    (state == B_KEY) |-> !s1_v && !q_pop)
    else $error("item issued during key derivation");
  a_done_in_key: assert property (@(posedge clk) disable iff (rst)
    key_done |-> (state == B_KEY))
    else $error("key done without a pending load");
`endif

endmodule

// ===== rtl/seeded_permutation_byte_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_permutation_byte_decoder_core
// Keyed substitution decoder: key loads build an inverse permutation table,
// decodes look a byte up and subtract the low file position, or pass it keyless.
// ----------------------------------------------------------------------------
//  channel   dir  sideband           payload
//  s_axis    in   tuser: cmd         tdata: seed, cipher_byte, position_low
//  m_axis    out  tuser: error       tdata: plain_byte
//
//  Decode items issue one per cycle while no key load runs and the output side
//  does not stall; each passes from the queue to the table read, then to the output register.
//  A valid key load runs the divide, a prep step, the identity fill, a
//  read then write swap step per round over the banked permutation memory
//  and the inverse sweep. A negative seed issues like a decode item.
//  Reset (rst, synchronous) clears the queue, the key flag and all control.
//  Either side may stall; a four-entry queue parts input from execution.
// ----------------------------------------------------------------------------
module seeded_permutation_byte_decoder_core #(
  parameter int SWAP_ROUNDS = spbd_pkg::SWAP_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] seed, [39:32] cipher_byte, [47:40] position_low
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] plain_byte
  output logic [0:0]  m_axis_tuser    // [0] error
);

  logic                  q_valid;
  spbd_pkg::queue_item_t q_item;
  logic                  q_pop;
  spbd_pkg::key_req_t    key_req;
  logic                  key_done;
  spbd_pkg::inv_wr_t     inv_wr;

  spbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser[0]),
    .in_seed   (s_axis_tdata[31:0]),
    .in_cipher (s_axis_tdata[39:32]),
    .in_pos    (s_axis_tdata[47:40]),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  spbd_keygen #(
    .SWAP_ROUNDS (SWAP_ROUNDS)
  ) u_keygen (
    .clk    (clk),
    .rst    (rst),
    .req    (key_req),
    .done   (key_done),
    .inv_wr (inv_wr)
  );

  spbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .key_req   (key_req),
    .key_done  (key_done),
    .inv_wr    (inv_wr),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_plain (m_axis_tdata),
    .out_error (m_axis_tuser[0])
  );

endmodule

// ===== test/tb_seeded_permutation_byte_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seeded_permutation_byte_decoder_core
// Self-checking bench for the keyed byte decoder. A shadow copy of the key
// table is rebuilt from every accepted seed, and each decoded byte is checked
// in order. Directed items hit the seed and byte extremes, rejected seeds and
// decoding before any key. A random stream of file-like byte runs with
// occasional key changes follows. Both stream sides stall at random, and the
// output side holds off once for a long stretch to back up the input queue.
// ----------------------------------------------------------------------------
module tb_seeded_permutation_byte_decoder_core;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_ITEMS = 530;
  localparam int          RANDOM_KEYS  = 10;
  localparam int          LONG_HOLD    = 300;
  localparam int          HOLD_AT      = 40;
  localparam int          DRAIN_CYCLES = 20;

  // Shadow of the decode table, plus the queue of bytes still owed by the DUT
  class key_table_tracker;
    typedef struct {
      logic [7:0] plain;
      logic       err;
    } decoded_t;

    logic [7:0] inv_tbl [spbd_pkg::TABLE_DEPTH];
    logic       key_valid;
    decoded_t   owed [$];
    int         mismatches;
    int         n_decodes;
    int         n_keys;
    int         n_rejected;

    function new();
      key_valid  = 1'b0;
      mismatches = 0;
      n_decodes  = 0;
      n_keys     = 0;
      n_rejected = 0;
    endfunction

    // Shuffle the identity table with the seeded adjacent swaps, then invert it
    function void build_inverse(logic [31:0] seed);
      int unsigned stride;
      int unsigned offset;
      int unsigned k;
      logic [7:0]  perm [spbd_pkg::TABLE_DEPTH];
      logic [7:0]  t;
      stride = spbd_pkg::STRIDE_BASE + seed % spbd_pkg::DIV_BASE;
      offset = seed / spbd_pkg::DIV_BASE;
      for (int i = 0; i < spbd_pkg::TABLE_DEPTH; i++) perm[i] = i[7:0];
      for (int unsigned r = 1; r <= spbd_pkg::SWAP_ROUNDS_DEF; r++) begin
        k = 1 + (r * stride + offset) % spbd_pkg::MOD_BASE;
        t = perm[k];
        perm[k] = perm[k + 1];
        perm[k + 1] = t;
      end
      for (int i = 0; i < spbd_pkg::TABLE_DEPTH; i++) inv_tbl[perm[i]] = i[7:0];
      key_valid = 1'b1;
    endfunction

    // Note an accepted input item and queue the byte it must produce
    function void take_item(logic cmd, logic [31:0] seed, logic [7:0] cbyte,
                            logic [7:0] pos);
      decoded_t d;
      d.plain = 8'h00;
      d.err   = 1'b0;
      if (cmd == spbd_pkg::CMD_LOAD) begin
        if (seed[31]) begin
          d.err = 1'b1;
          n_rejected++;
        end else begin
          build_inverse(seed);
          n_keys++;
        end
      end else begin
        d.plain = key_valid ? inv_tbl[cbyte] - pos : cbyte;
        n_decodes++;
      end
      owed.push_back(d);
    endfunction

    // Compare one output item with the oldest owed byte
    function void check_output(logic [7:0] plain, logic err);
      decoded_t d;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: expected no output, got plain %h error %b", $time, plain, err);
        return;
      end
      d = owed.pop_front();
      if (plain !== d.plain || err !== d.err) begin
        mismatches++;
        $display("%0t: mismatch plain exp %h got %h, error exp %b got %b",
                 $time, d.plain, plain, d.err, err);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [31:0] seed, [39:32] cipher_byte, [47:40] position_low
  logic [0:0]  s_axis_tuser = '0;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] plain_byte
  logic [0:0]  m_axis_tuser;        // [0] error

  key_table_tracker tracker = new();
  logic        quiet_sender = 1'b0;
  int unsigned cycles = 0;

  seeded_permutation_byte_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic cmd, input logic [31:0] seed,
                           input logic [7:0] cbyte, input logic [7:0] pos);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, cbyte, seed};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    tracker.take_item(cmd, seed, cbyte, pos);
  endtask

  // Output side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) stall = LONG_HOLD;
      else if ((taken / 50) % 3 == 2) stall = 0;
      else stall = $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (m_axis_tvalid !== 1'b1) @(posedge clk);
      tracker.check_output(m_axis_tdata, m_axis_tuser[0]);
      taken++;
    end
  end

  // Abort on a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] seed;
    logic [7:0]  file_pos;
    int          keys_left;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Decode before any key: bytes pass through, position ignored
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h00, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_item(spbd_pkg::CMD_DECODE, 32'h5555_AAAA, 8'hA5, 8'h5A);
    // Rejected seeds leave the block without a key
    send_item(spbd_pkg::CMD_LOAD, 32'h8000_0000, 8'hFF, 8'hFF);
    send_item(spbd_pkg::CMD_DECODE, 32'h1234_5678, 8'h3C, 8'hC3);
    send_item(spbd_pkg::CMD_LOAD, 32'hFFFF_FFFF, 8'h00, 8'h00);
    // Smallest seed, byte and position extremes
    send_item(spbd_pkg::CMD_LOAD, 32'h0000_0000, 8'h00, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h00, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h00, 8'hFF);
    send_item(spbd_pkg::CMD_DECODE, 32'hFFFF_FFFF, 8'hFF, 8'h00);
    // Largest seed
    send_item(spbd_pkg::CMD_LOAD, 32'h7FFF_FFFF, 8'h00, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h01, 8'h80);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h80, 8'h01);
    // A rejected seed keeps the earlier key in force
    send_item(spbd_pkg::CMD_LOAD, 32'h8000_0001, 8'hAA, 8'h55);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h7F, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'hFE, 8'h10);
    // Widest stride, then smallest stride with a nonzero offset
    send_item(spbd_pkg::CMD_LOAD, 32'd249, 8'h00, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h42, 8'h07);
    send_item(spbd_pkg::CMD_LOAD, 32'd250, 8'h00, 8'h00);
    send_item(spbd_pkg::CMD_DECODE, 32'h0000_0000, 8'h42, 8'h07);

    // Random byte runs at advancing positions, with the odd key change
    keys_left = RANDOM_KEYS;
    file_pos  = 8'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_sender = ((n / 60) % 3) == 1;
      if ($urandom_range(0, 39) == 0) begin
        seed = $urandom;
        if (keys_left > 0 && $urandom_range(0, 4) < 3) begin
          seed[31] = 1'b0;
          keys_left--;
        end else begin
          seed[31] = 1'b1;
        end
        send_item(spbd_pkg::CMD_LOAD, seed, 8'($urandom), 8'($urandom));
        file_pos = 8'($urandom);
      end else begin
        if ($urandom_range(0, 7) == 0) file_pos = 8'($urandom);
        send_item(spbd_pkg::CMD_DECODE, $urandom, 8'($urandom), file_pos);
        file_pos++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give stray outputs a chance to show up
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d decoded bytes, %0d keys built, %0d seeds rejected",
             tracker.n_decodes, tracker.n_keys, tracker.n_rejected);
    $display("with random stalls on both sides and one %0d-cycle output hold",
             LONG_HOLD);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
